@@ rtl/core/bmf_pkg.sv @@
// Package with the shared types and constants of the block median filter.
`default_nettype none

package bmf_pkg;

    // Data and configuration widths, the default row length and the reset window size.
    localparam int SAMPLE_W           = 32;
    localparam int CFG_W              = 5;
    localparam int DEFAULT_MAX_WINDOW = 16;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd3;

    // One input request.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } s_payload_t;

    // One result request.
    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                ready_res;
    } m_payload_t;

    // Per-cycle command that every sorting cell receives.
    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // Control states of the filter.
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } bmf_state_t;

endpackage

`default_nettype wire

@@ rtl/core/bmf_cell.sv @@
// One sorting cell: holds a sample, its arrival position and a valid bit.
`default_nettype none

module bmf_cell import bmf_pkg::*; #(
    parameter int TAG_W = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [SAMPLE_W-1:0] ins_value,
    input  wire logic [TAG_W-1:0]    ins_tag,
    input  wire logic                lower_gt,
    input  wire logic                lower_valid,
    input  wire logic [SAMPLE_W-1:0] lower_value,
    input  wire logic [TAG_W-1:0]    lower_tag,
    input  wire logic                upper_valid,
    input  wire logic [SAMPLE_W-1:0] upper_value,
    input  wire logic [TAG_W-1:0]    upper_tag,
    output logic                     cell_valid,
    output logic [SAMPLE_W-1:0]      cell_value,
    output logic [TAG_W-1:0]         cell_tag,
    output logic                     cell_gt
);

    logic                valid_reg, valid_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;

    // The new sample belongs at or below this cell when the cell is empty or larger.
    assign cell_gt = !valid_reg || (value_reg > ins_value);

    // Clear empties the cell; insert keeps, takes the new sample, or shifts up from below; drain shifts down.
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        tag_next   = tag_reg;
        priority if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.insert) begin
            if (cell_gt) begin
                if (!lower_gt) begin
                    valid_next = 1'b1;
                    value_next = ins_value;
                    tag_next   = ins_tag;
                end else begin
                    valid_next = lower_valid;
                    value_next = lower_value;
                    tag_next   = lower_tag;
                end
            end
        end else if (ctrl.shift) begin
            valid_next = upper_valid;
            value_next = upper_value;
            tag_next   = upper_tag;
        end else begin
            // With no command the cell keeps what it holds.
            valid_next = valid_reg;
            value_next = value_reg;
            tag_next   = tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        tag_reg   <= tag_next;
    end

    assign cell_valid = valid_reg;
    assign cell_value = value_reg;
    assign cell_tag   = tag_reg;

endmodule

`default_nettype wire

@@ rtl/core/bmf_chain.sv @@
// Row of sorting cells kept in ascending order, smallest sample at the head.
`default_nettype none

module bmf_chain import bmf_pkg::*; #(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW,
    parameter int TAG_W      = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [SAMPLE_W-1:0] ins_value,
    input  wire logic [TAG_W-1:0]    ins_tag,
    output logic                     head_valid,
    output logic [SAMPLE_W-1:0]      head_value,
    output logic [TAG_W-1:0]         head_tag
);

    logic [MAX_WINDOW-1:0] valid_w;
    logic [MAX_WINDOW-1:0] gt_w;
    logic [SAMPLE_W-1:0]   value_w [MAX_WINDOW];
    logic [TAG_W-1:0]      tag_w   [MAX_WINDOW];

    // Each cell talks to its two neighbors; the ends see an empty neighbor.
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic                lo_gt, lo_valid, up_valid;
        logic [SAMPLE_W-1:0] lo_value, up_value;
        logic [TAG_W-1:0]    lo_tag, up_tag;

        if (i == 0) begin : g_bottom
            assign lo_gt    = 1'b0;
            assign lo_valid = 1'b0;
            assign lo_value = '0;
            assign lo_tag   = '0;
        end else begin : g_lower
            assign lo_gt    = gt_w[i-1];
            assign lo_valid = valid_w[i-1];
            assign lo_value = value_w[i-1];
            assign lo_tag   = tag_w[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_top
            assign up_valid = 1'b0;
            assign up_value = '0;
            assign up_tag   = '0;
        end else begin : g_upper
            assign up_valid = valid_w[i+1];
            assign up_value = value_w[i+1];
            assign up_tag   = tag_w[i+1];
        end

        bmf_cell #(
            .TAG_W(TAG_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .ins_value   (ins_value),
            .ins_tag     (ins_tag),
            .lower_gt    (lo_gt),
            .lower_valid (lo_valid),
            .lower_value (lo_value),
            .lower_tag   (lo_tag),
            .upper_valid (up_valid),
            .upper_value (up_value),
            .upper_tag   (up_tag),
            .cell_valid  (valid_w[i]),
            .cell_value  (value_w[i]),
            .cell_tag    (tag_w[i]),
            .cell_gt     (gt_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_value = value_w[0];
    assign head_tag   = tag_w[0];

endmodule

`default_nettype wire

@@ rtl/core/block_median_filter.sv @@
// Top level of the non-overlapping block median filter.
//
// Input requests arrive on s_valid/s_ready/s_data (sample and restart flag);
// every accepted request yields exactly one result request on
// m_valid/m_ready/m_data (median and ready_res). cfg_we/cfg_wdata write the
// window size; write it only while the filter is idle (the block does not enforce this).
// Each sample is inserted into the sorted row of cells as it is accepted; a
// sample that does not close a block is accepted every cycle while the output
// register is free; its result (median 0, ready_res 0) is there the next cycle.
// The sample that closes a block is followed by a drain: the row shifts
// toward its head one cell a cycle until the middle element of the block
// reaches it; s_ready is low during the drain.
// A restart request empties the row and returns median 0, ready_res 0.
// Reset empties the row, clears the fill count and sets the window size to 3.
// When the receiver stalls, the output register holds its result and s_ready
// drops until the result is taken; a drain waits at its last step.
`default_nettype none

module block_median_filter import bmf_pkg::*; #(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire s_payload_t       s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output m_payload_t            m_data
);

    localparam int TagW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SizeRW = $clog2(MAX_WINDOW + 1);
    localparam int SizeW  = (SizeRW > CFG_W) ? SizeRW : CFG_W;
    localparam logic [SizeW-1:0] MaxSize = SizeW'(MAX_WINDOW);

    bmf_state_t       state_reg, state_next;
    logic [CFG_W-1:0] window_size_reg, window_size_next;
    logic [TagW-1:0]  fill_count_reg, fill_count_next;
    logic [SizeW-1:0] rank_reg, rank_next;
    logic             m_valid_reg, m_valid_next;
    m_payload_t       m_data_reg, m_data_next;

    logic             s_fire, out_free, complete, counted, found;
    logic [SizeW-1:0] size_raw, eff_size, fill_plus, mid_rank;
    cell_ctrl_t       ctrl;
    logic             head_valid;
    logic [SAMPLE_W-1:0] head_value;
    logic [TagW-1:0]  head_tag;

    // Effective window: zero acts as one, larger than the row saturates.
    always_comb begin
        size_raw = SizeW'(window_size_reg);
        if (size_raw == '0) begin
            eff_size = SizeW'(1);
        end else if (size_raw > MaxSize) begin
            eff_size = MaxSize;
        end else begin
            eff_size = size_raw;
        end
    end

    assign mid_rank  = eff_size >> 1;
    assign fill_plus = SizeW'(fill_count_reg) + SizeW'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign complete  = !s_data.restart && (fill_plus >= eff_size);

    // Only samples whose arrival position lies inside the window count toward the median.
    assign counted = head_valid && (SizeW'(head_tag) < eff_size);
    assign found   = counted && (rank_reg == mid_rank);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (s_fire && complete) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (found && out_free) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        s_ready          = 1'b0;
        ctrl             = '0;
        fill_count_next  = fill_count_reg;
        rank_next        = rank_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        window_size_next = cfg_we ? cfg_wdata : window_size_reg;
        unique case (state_reg)
            ST_FILL: begin
                s_ready = out_free;
                if (s_fire) begin
                    if (s_data.restart) begin
                        ctrl.clear      = 1'b1;
                        fill_count_next = '0;
                        m_valid_next    = 1'b1;
                        m_data_next     = '0;
                    end else begin
                        ctrl.insert = 1'b1;
                        if (complete) begin
                            fill_count_next = '0;
                            rank_next       = '0;
                        end else begin
                            fill_count_next = fill_count_reg + TagW'(1);
                            m_valid_next    = 1'b1;
                            m_data_next     = '0;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (found) begin
                    if (out_free) begin
                        ctrl.clear            = 1'b1;
                        m_valid_next          = 1'b1;
                        m_data_next.median    = head_value;
                        m_data_next.ready_res = 1'b1;
                    end
                end else begin
                    ctrl.shift = 1'b1;
                    rank_next  = rank_reg + SizeW'(counted);
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    bmf_chain #(
        .MAX_WINDOW (MAX_WINDOW),
        .TAG_W      (TagW)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .ins_value  (s_data.sample),
        .ins_tag    (fill_count_reg),
        .head_valid (head_valid),
        .head_value (head_value),
        .head_tag   (head_tag)
    );

    // Control and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_FILL;
            window_size_reg <= WINDOW_RESET;
            fill_count_reg  <= '0;
            rank_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            fill_count_reg  <= fill_count_next;
            rank_reg        <= rank_next;
            m_valid_reg     <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // New requests are taken only while the row is filling.
    a_ready_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_FILL))
        else $error("s_ready high outside the fill state");

    // A restart leaves the row empty.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.restart) |=> !head_valid)
        else $error("row not empty after restart");

    // During a drain the head always holds a sample until the median is found.
    a_drain_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> head_valid)
        else $error("row ran empty during drain");

    // A finished drain puts a valid median in the output register.
    a_drain_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && found && out_free) |=> (m_valid && m_data.ready_res))
        else $error("drain finished without a median result");

    // The fill position never leaves the row.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (TagW + 1)'(fill_count_reg) < (TagW + 1)'(MAX_WINDOW))
        else $error("fill count beyond the row");

endmodule

`default_nettype wire

@@ sim/block_median_filter_checker.sv @@
// Checker that predicts and compares every result of the block median filter.
`timescale 1ns / 1ps

module block_median_filter_checker import bmf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire s_payload_t       s_data,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire m_payload_t       m_data,
    output int                    mismatches,
    output int                    outstanding
);

    localparam int MAX_W = DEFAULT_MAX_WINDOW;

    // Predicted filter state: the sample row, its fill position and the window register.
    logic [SAMPLE_W-1:0] row [MAX_W];
    int unsigned         fill_pos;
    logic [CFG_W-1:0]    window;

    // Expected results, oldest first.
    m_payload_t median_q [$];

    // Prints one line per mismatch (the first few only) and counts every one.
    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                   input logic [SAMPLE_W-1:0] want);
        if (mismatches < 40) begin
            $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Works out the result of one accepted request and advances the predicted state.
    function automatic m_payload_t predict_median(input s_payload_t req);
        int unsigned         span;
        int unsigned         i;
        int unsigned         j;
        logic [SAMPLE_W-1:0] key;
        m_payload_t          res;
        res = '0;
        // A window of zero acts as one; anything above the row length saturates.
        span = (window == 0) ? 1 : ((window > MAX_W) ? MAX_W : window);
        if (req.restart) begin
            fill_pos = 0;
        end else begin
            if (fill_pos < MAX_W) begin
                row[fill_pos] = req.sample;
            end
            if (fill_pos + 1 < span) begin
                fill_pos++;
            end else begin
                // The block is complete: sort its first span entries and take the middle.
                for (i = 1; i < span; i++) begin
                    key = row[i];
                    j = i;
                    while (j > 0 && row[j-1] > key) begin
                        row[j] = row[j-1];
                        j--;
                    end
                    row[j] = key;
                end
                res.median    = row[span / 2];
                res.ready_res = 1'b1;
                fill_pos      = 0;
            end
        end
        return res;
    endfunction

    // Watch both channels and the register port at every edge.
    always @(posedge aclk) begin
        m_payload_t want;
        if (!aresetn) begin
            for (int k = 0; k < MAX_W; k++) begin
                row[k] = '0;
            end
            fill_pos   = 0;
            window     = WINDOW_RESET;
            mismatches = 0;
            median_q.delete();
        end else begin
            if (cfg_we) begin
                window = cfg_wdata;
            end
            // Results are compared before the request of this edge is predicted.
            if (m_valid && m_ready) begin
                if (median_q.size() == 0) begin
                    report_mismatch("result with no request waiting", m_data.median, '0);
                end else begin
                    want = median_q.pop_front();
                    if (m_data.median !== want.median) begin
                        report_mismatch("median", m_data.median, want.median);
                    end
                    if (m_data.ready_res !== want.ready_res) begin
                        report_mismatch("ready_res", {31'd0, m_data.ready_res},
                                        {31'd0, want.ready_res});
                    end
                end
            end
            if (s_valid && s_ready) begin
                median_q.push_back(predict_median(s_data));
            end
        end
        outstanding <= median_q.size();
    end

endmodule

@@ sim/block_median_filter_test.sv @@
// Testbench top for the block median filter: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module block_median_filter_test;
    import bmf_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int LONG_HOLD   = 120;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid   = 1'b0;
    s_payload_t       s_data    = '0;
    logic             m_ready   = 1'b0;
    logic             s_ready;
    logic             m_valid;
    m_payload_t       m_data;

    int mismatches;
    int outstanding;
    int sent          = 0;
    int burst_left    = 0;
    int hold_requests = 0;

    always #2 aclk = ~aclk;

    block_median_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    block_median_filter_checker median_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offers one request, in bursts with random gaps, and returns at the edge that takes it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
        s_payload_t req;
        req.sample  = value;
        req.restart = restart;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom % 4 != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Writes the window register once the filter is idle.
    task automatic set_window(input logic [CFG_W-1:0] size);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mix of extremes, values clustered near zero and near the sign bit for duplicates, and full-range values.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom % 8)
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 7);
            3: return 32'h8000_0000 | $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Window sizes with the edges, zero and the saturating range weighted up.
    function automatic logic [CFG_W-1:0] pick_window();
        case ($urandom % 10)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return CFG_W'($urandom_range(17, 31));
            default: return CFG_W'($urandom_range(2, 15));
        endcase
    endfunction

    // Receiver: stall patterns that change by segment, plus the long hold on request.
    initial begin
        int holds_done;
        int mode;
        int seg;
        holds_done = 0;
        mode       = 0;
        seg        = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else begin
                if (seg == 0) begin
                    mode = $urandom % 4;
                    seg  = $urandom_range(10, 60);
                end
                seg--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom % 2 == 0);
                    2: m_ready <= ($urandom % 10 != 0);
                    default: m_ready <= ($urandom % 4 == 0);
                endcase
            end
        end
    end

    // Run time guard.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int phase;
        int len;
        phase = 0;
        len   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window of three with the sample extremes.
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        // A restart drops the partial block; the next three form a fresh one.
        send_sample(32'd5, 1'b0);
        send_sample('1, 1'b1);
        send_sample(32'd7, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd9, 1'b0);
        // Window of one: every sample is its own median.
        set_window(5'd1);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        // Window of zero behaves as one.
        set_window(5'd0);
        send_sample(32'h1234_5678, 1'b0);
        // Even window takes the upper middle.
        set_window(5'd2);
        send_sample(32'd10, 1'b0);
        send_sample(32'd20, 1'b0);
        // Shrink the window mid-block: the next sample closes the block.
        set_window(5'd4);
        send_sample(32'd300, 1'b0);
        send_sample(32'd100, 1'b0);
        send_sample(32'd200, 1'b0);
        set_window(5'd2);
        send_sample(32'd50, 1'b0);

        // Random phases, each with its own window; partial blocks carry across writes.
        while (sent < ITEM_TARGET) begin
            case (phase)
                0: set_window(5'd16);
                1: set_window(5'd31);
                2: set_window(5'd1);
                default: set_window(pick_window());
            endcase
            len = $urandom_range(20, 90);
            if (phase == 3) begin
                hold_requests <= hold_requests + 1;
            end
            for (int i = 0; i < len; i++) begin
                if (phase == 5 && i == len / 2) begin
                    wait_idle();
                end
                send_sample(pick_sample(), $urandom % 100 < 4);
            end
            phase++;
        end

        wait_idle();
        repeat (2 * DEFAULT_MAX_WINDOW) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
